### rtl/kaufman_adaptive_moving_average_core_assert.svh
// ----------------------------------------------------------------------------
// KAMA assertion macros
// Concurrent assertion wrappers used by the adaptive average core. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef KAUFMAN_ADAPTIVE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define KAUFMAN_ADAPTIVE_MOVING_AVERAGE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication or invariant, checked at every clock edge out of reset.
`define KAMA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define KAMA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define KAMA_ASSERT(name, clk, rst_n, prop, msg)

`define KAMA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/kama_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KAMA package
// Widths, reset values, register indexes, controller states and the divider
// request and status structs shared by the adaptive average core.
// ----------------------------------------------------------------------------
package kama_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int PRICE_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int AVG_W         = 48;
    localparam int PATH_W        = 38;
    localparam int SEED_W        = 40;
    localparam int COUNT_W       = 16;
    localparam int WIN_W         = 6;
    localparam int PERIOD_W      = 8;
    localparam int COEF_W        = FRAC_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd2;

    localparam logic [WIN_W-1:0]    WINDOW_RST = 6'd10;
    localparam logic [PERIOD_W-1:0] FAST_RST   = 8'd2;
    localparam logic [PERIOD_W-1:0] SLOW_RST   = 8'd30;

    localparam logic [COEF_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};
    localparam int FAST_COEF_INT = (2 * (1 << FRAC_W)) / (int'(FAST_RST) + 1);
    localparam int SLOW_COEF_INT = (2 * (1 << FRAC_W)) / (int'(SLOW_RST) + 1);
    localparam logic [COEF_W-1:0] FAST_COEF_RST = COEF_W'(FAST_COEF_INT);
    localparam logic [COEF_W-1:0] SLOW_COEF_RST = COEF_W'(SLOW_COEF_INT);

    // iterative divider
    localparam int DIV_SH_W   = SEED_W + FRAC_W;
    localparam int DIV_REM_W  = PATH_W;
    localparam int DIV_CNT_W  = $clog2(DIV_SH_W + 1);
    // numerator 2.0 in Q.16 is an 18-bit value; left-aligned it is only the top bit
    localparam int COEF_NUM_W = FRAC_W + 2;
    localparam logic [DIV_SH_W-1:0] COEF_DIVIDEND = DIV_SH_W'(1) << (DIV_SH_W - 1);

    // shared multiplier: the 48-bit difference goes through in two halves
    localparam int MUL_A_W = AVG_W / 2;
    localparam int MUL_B_W = COEF_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_COEF_FAST,
        S_WAIT_FAST,
        S_COEF_SLOW,
        S_WAIT_SLOW,
        S_RD_PREV,
        S_RD_OLD,
        S_CALC,
        S_DECIDE,
        S_WAIT_ER,
        S_WAIT_SEED,
        S_MUL_FAST,
        S_MUL_SLOW,
        S_LIN,
        S_MUL_LIN,
        S_SC,
        S_MUL_LO,
        S_MUL_HI,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_SH_W-1:0]  dividend;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

### rtl/kaufman_adaptive_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kaufman adaptive moving average core
// One closing price in, one Q32.16 adaptive average out, with warm-up flag.
// ----------------------------------------------------------------------------
// The core takes one closing price per item (unsigned ticks) and returns one
// item holding the adaptive average in unsigned Q32.16 plus a warm-up flag;
// during the first slow_period items the average reads zero and the flag is
// set, and the item that completes warm-up seeds the average with the mean of
// those closes. Closes and absolute close-to-close steps live in two 64-entry
// rings held in synchronous RAMs; each item reads the previous close and the
// close and step that leave the efficiency window, then writes its own entry
// back. The efficiency ratio comes from a shared one-bit-per-cycle divider,
// and the smoothing constant and update from one registered 24x17 multiplier
// used five times. One item is in flight at a time; no division is run when
// the ratio is trivially zero or one, the ratio otherwise needs the 16-step
// division, and the seeding item's mean is a 56-step division.
// Results wait in an output register, so the next item is taken while the
// last result is still unclaimed. Any write to a known register restarts
// the core (counts, sums, average, ring position) and recomputes both EMA
// coefficients with the divider, during which neither items nor further
// writes are taken. The configuration port is meant to be used only while
// the core is idle.
// ----------------------------------------------------------------------------
module kaufman_adaptive_moving_average_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kama_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kama_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kama_pkg::PRICE_W-1:0]        s_axis_tdata,  // [31:0] close_price
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kama_pkg::AVG_W-1:0]          m_axis_tdata,  // [47:0] average_value
    output logic                                m_axis_tuser   // [0] warming_up
);
    import kama_pkg::*;

`include "kaufman_adaptive_moving_average_core_assert.svh"

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] slot_back(input logic [ADDR_W-1:0] pos,
                                                    input logic [WIN_W-1:0]  back);
        logic [ADDR_W:0] p;
        logic [ADDR_W:0] b;
        p = {1'b0, pos};
        b = (ADDR_W+1)'(back);
        if (p >= b) begin
            return ADDR_W'(p - b);
        end
        return ADDR_W'(int'(p) + HISTORY_DEPTH - int'(b));
    endfunction

    function automatic logic [PERIOD_W-1:0] period_eff(input logic [PERIOD_W-1:0] n);
        return (n == '0) ? PERIOD_W'(1) : n;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [WIN_W-1:0]    r_window;
    logic [PERIOD_W-1:0] r_fast_period;
    logic [PERIOD_W-1:0] r_slow_period;
    logic [COEF_W-1:0]   r_fast_coef;
    logic [COEF_W-1:0]   r_slow_coef;

    logic [COUNT_W-1:0]  r_count;
    logic [ADDR_W-1:0]   r_pos;
    logic [PATH_W-1:0]   r_path;
    logic [SEED_W-1:0]   r_seed;
    logic [AVG_W-1:0]    r_avg;

    logic [PRICE_W-1:0]  r_close;
    logic [PRICE_W-1:0]  r_prev_close;
    logic [PRICE_W-1:0]  r_old_step;
    logic [PRICE_W-1:0]  r_change;
    logic [COEF_W-1:0]   r_er;
    logic [MUL_P_W-1:0]  r_acc;
    logic [MUL_P_W-1:0]  r_prod;
    logic [COEF_W-1:0]   r_lin;
    logic [COEF_W-1:0]   r_sc;
    logic [AVG_W-1:0]    r_diff;
    logic                r_up;

    logic                r_out_valid;
    logic [AVG_W-1:0]    r_out_avg;
    logic                r_out_warm;

    // ------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]    w_eff;
    logic [PERIOD_W-1:0] s_eff;
    logic                is_warm;
    logic                seed_last;
    logic                has_prev;
    logic                full_win;
    logic [ADDR_W-1:0]   prev_slot;
    logic [ADDR_W-1:0]   old_slot;
    logic                cfg_known;
    logic                cfg_fire;
    logic                in_fire;
    logic                out_free;
    logic                out_load;

    logic [PRICE_W-1:0]  close_rdata;
    logic [PRICE_W-1:0]  step_rdata;
    logic [ADDR_W-1:0]   close_raddr;
    logic                ring_we;
    logic [PRICE_W-1:0]  step_val;
    logic [PATH_W-1:0]   path_add;
    logic [PATH_W-1:0]   path_new;
    logic [PRICE_W-1:0]  change_val;
    logic [AVG_W-1:0]    target;
    logic                er_active;
    logic                er_full;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W:0]    lin_sum;
    logic [MUL_P_W-FRAC_W-1:0]   sc_raw;
    logic [MUL_P_W+MUL_A_W-1:0]  upd_sum;
    logic [AVG_W-1:0]    delta;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [DIV_SH_W-1:0] div_quot;

    always_comb begin
        w_eff     = (int'(r_window) > HISTORY_DEPTH - 1) ? WIN_W'(HISTORY_DEPTH - 1) : r_window;
        s_eff     = period_eff(r_slow_period);
        is_warm   = (r_count < COUNT_W'(s_eff));
        seed_last = (r_count == COUNT_W'(s_eff) - COUNT_W'(1));
        has_prev  = (r_count != '0);
        full_win  = (r_count >= COUNT_W'(w_eff));
        prev_slot = slot_back(r_pos, WIN_W'(1));
        old_slot  = slot_back(r_pos, w_eff);
        cfg_known = (i_cfg_index == CFG_WINDOW) || (i_cfg_index == CFG_FAST) ||
                    (i_cfg_index == CFG_SLOW);
        cfg_fire  = i_cfg_valid && o_cfg_ready;
        in_fire   = s_axis_tvalid && s_axis_tready;
        out_free  = !r_out_valid || m_axis_tready;
    end

    // step, path length and net change (the old close arrives in S_CALC)
    always_comb begin
        step_val   = !has_prev ? '0 :
                     (r_close >= r_prev_close) ? r_close - r_prev_close
                                               : r_prev_close - r_close;
        path_add   = r_path + PATH_W'(step_val);
        if (w_eff == '0) begin
            path_new = '0;
        end else if (full_win) begin
            path_new = path_add - PATH_W'(r_old_step);
        end else begin
            path_new = path_add;
        end
        change_val = (r_close >= close_rdata) ? r_close - close_rdata : close_rdata - r_close;
        target     = AVG_W'({r_close, {FRAC_W{1'b0}}});
        er_active  = (w_eff != '0) && full_win && (r_path != '0);
        er_full    = (PATH_W'(r_change) >= r_path);
    end

    // multiplier post-processing
    always_comb begin
        lin_sum = {1'b0, r_acc} + {1'b0, r_prod};
        sc_raw  = r_prod[MUL_P_W-1:FRAC_W];
        upd_sum = {r_prod, {MUL_A_W{1'b0}}} + (MUL_P_W+MUL_A_W)'(r_acc);
        delta   = upd_sum[FRAC_W+AVG_W-1:FRAC_W];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cfg_fire && cfg_known) begin
                    n_state = S_COEF_FAST;
                end else if (in_fire) begin
                    n_state = S_RD_PREV;
                end
            end
            S_COEF_FAST: n_state = S_WAIT_FAST;
            S_WAIT_FAST: begin
                if (div_rsp.done) begin
                    n_state = S_COEF_SLOW;
                end
            end
            S_COEF_SLOW: n_state = S_WAIT_SLOW;
            S_WAIT_SLOW: begin
                if (div_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_PREV: n_state = S_RD_OLD;
            S_RD_OLD:  n_state = S_CALC;
            S_CALC:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (is_warm) begin
                    n_state = seed_last ? S_WAIT_SEED : S_OUT;
                end else if (er_active && !er_full) begin
                    n_state = S_WAIT_ER;
                end else begin
                    n_state = S_MUL_FAST;
                end
            end
            S_WAIT_ER: begin
                if (div_rsp.done) begin
                    n_state = S_MUL_FAST;
                end
            end
            S_WAIT_SEED: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_MUL_FAST: n_state = S_MUL_SLOW;
            S_MUL_SLOW: n_state = S_LIN;
            S_LIN:      n_state = S_MUL_LIN;
            S_MUL_LIN:  n_state = S_SC;
            S_SC:       n_state = S_MUL_LO;
            S_MUL_LO:   n_state = S_MUL_HI;
            S_MUL_HI:   n_state = S_UPDATE;
            S_UPDATE:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs: handshakes, ring access, divider and multiplier steering
    // ------------------------------------------------------------------
    always_comb begin
        o_cfg_ready   = 1'b0;
        s_axis_tready = 1'b0;
        close_raddr   = prev_slot;
        ring_we       = 1'b0;
        out_load      = 1'b0;
        div_req       = '0;
        mul_a         = '0;
        mul_b         = '0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready   = 1'b1;
                // a pending write wins over an item
                s_axis_tready = !i_cfg_valid;
            end
            S_COEF_FAST: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(COEF_NUM_W);
                div_req.dividend = COEF_DIVIDEND;
                div_req.divisor  = DIV_REM_W'(period_eff(r_fast_period)) + DIV_REM_W'(1);
            end
            S_COEF_SLOW: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(COEF_NUM_W);
                div_req.dividend = COEF_DIVIDEND;
                div_req.divisor  = DIV_REM_W'(period_eff(r_slow_period)) + DIV_REM_W'(1);
            end
            S_RD_OLD: close_raddr = old_slot;
            S_CALC:   ring_we     = 1'b1;
            S_DECIDE: begin
                if (is_warm) begin
                    if (seed_last) begin
                        div_req.start    = 1'b1;
                        div_req.count    = DIV_CNT_W'(DIV_SH_W);
                        div_req.dividend = {r_seed, {FRAC_W{1'b0}}};
                        div_req.divisor  = DIV_REM_W'(s_eff);
                    end
                end else if (er_active && !er_full) begin
                    // change < path: preload the remainder, shift in 16 zero bits
                    div_req.start    = 1'b1;
                    div_req.count    = DIV_CNT_W'(FRAC_W);
                    div_req.rem_init = DIV_REM_W'(r_change);
                    div_req.divisor  = r_path;
                end
            end
            S_MUL_FAST: begin
                mul_a = MUL_A_W'(r_er);
                mul_b = r_fast_coef;
            end
            S_MUL_SLOW: begin
                mul_a = MUL_A_W'(Q_ONE - r_er);
                mul_b = r_slow_coef;
            end
            S_MUL_LIN: begin
                mul_a = MUL_A_W'(r_lin);
                mul_b = r_lin;
            end
            S_MUL_LO: begin
                mul_a = r_diff[MUL_A_W-1:0];
                mul_b = r_sc;
            end
            S_MUL_HI: begin
                mul_a = r_diff[AVG_W-1:MUL_A_W];
                mul_b = r_sc;
            end
            S_OUT: out_load = out_free;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // ring memories
    // ------------------------------------------------------------------
    kama_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (PRICE_W)
    ) u_close_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (r_close),
        .i_raddr (close_raddr),
        .o_rdata (close_rdata)
    );

    kama_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (PRICE_W)
    ) u_step_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (step_val),
        .i_raddr (old_slot),
        .o_rdata (step_rdata)
    );

    kama_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window      <= WINDOW_RST;
            r_fast_period <= FAST_RST;
            r_slow_period <= SLOW_RST;
            r_fast_coef   <= FAST_COEF_RST;
            r_slow_coef   <= SLOW_COEF_RST;
            r_count       <= '0;
            r_pos         <= '0;
            r_path        <= '0;
            r_seed        <= '0;
            r_avg         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // restart on any write to a known register
            if (r_state == S_IDLE && cfg_fire && cfg_known) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window      <= i_cfg_data[WIN_W-1:0];
                    CFG_FAST:   r_fast_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_SLOW:   r_slow_period <= i_cfg_data[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
                r_count <= '0;
                r_pos   <= '0;
                r_path  <= '0;
                r_seed  <= '0;
                r_avg   <= '0;
            end

            if (r_state == S_WAIT_FAST && div_rsp.done) begin
                r_fast_coef <= div_quot[COEF_W-1:0];
            end
            if (r_state == S_WAIT_SLOW && div_rsp.done) begin
                r_slow_coef <= div_quot[COEF_W-1:0];
            end

            if (r_state == S_CALC) begin
                r_path <= path_new;
                if (is_warm) begin
                    r_seed <= r_seed + SEED_W'(r_close);
                end
            end

            if (r_state == S_WAIT_SEED && div_rsp.done) begin
                r_avg <= div_quot[AVG_W-1:0];
            end

            // move toward the target by the truncated step
            if (r_state == S_UPDATE) begin
                r_avg <= r_up ? r_avg + delta : r_avg - delta;
            end

            // advance count and ring position once the result is handed over
            if (out_load) begin
                r_pos <= (int'(r_pos) == HISTORY_DEPTH - 1) ? '0 : r_pos + ADDR_W'(1);
                if (r_count != '1) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (in_fire) begin
            r_close <= s_axis_tdata;
        end

        case (r_state)
            S_RD_OLD: begin
                r_prev_close <= close_rdata;
                r_old_step   <= step_rdata;
            end
            S_CALC: r_change <= change_val;
            S_DECIDE: begin
                r_diff <= (target >= r_avg) ? target - r_avg : r_avg - target;
                r_up   <= (target >= r_avg);
                if (!er_active) begin
                    r_er <= '0;
                end else if (er_full) begin
                    r_er <= Q_ONE;
                end
            end
            S_WAIT_ER: begin
                if (div_rsp.done) begin
                    r_er <= {1'b0, div_quot[FRAC_W-1:0]};
                end
            end
            S_MUL_SLOW: r_acc <= r_prod;
            S_LIN:      r_lin <= lin_sum[FRAC_W+COEF_W-1:FRAC_W];
            S_SC: begin
                r_sc <= (sc_raw > (MUL_P_W-FRAC_W)'(Q_ONE)) ? Q_ONE : sc_raw[COEF_W-1:0];
            end
            S_MUL_HI: r_acc <= r_prod;
            default: begin
            end
        endcase

        if (out_load) begin
            r_out_avg  <= is_warm ? '0 : r_avg;
            r_out_warm <= is_warm;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_avg;
    assign m_axis_tuser  = r_out_warm;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `KAMA_ASSERT(a_warm_zero, i_clk, i_rst_n, (r_out_valid && r_out_warm) |-> (r_out_avg == '0), "warm-up result carries a nonzero average")
    `KAMA_ASSERT(a_div_idle, i_clk, i_rst_n, div_req.start |-> !div_rsp.busy, "divider started while busy")
    `KAMA_ASSERT_NEXT(a_item_read, i_clk, i_rst_n, in_fire, r_state == S_RD_PREV, "accepted item did not start the ring read")
    `KAMA_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_fire, (r_state == S_COEF_FAST) || (r_state == S_IDLE), "configuration write did not restart the core")

endmodule

### rtl/kama_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KAMA ring memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module kama_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kama_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KAMA divider
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned and shifted out MSB first while quotient bits enter at the LSB.
// ----------------------------------------------------------------------------
module kama_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kama_pkg::t_div_req              i_req,
    output kama_pkg::t_div_rsp              o_rsp,
    output logic [kama_pkg::DIV_SH_W-1:0]   o_quot
);
    import kama_pkg::*;

    logic [DIV_SH_W-1:0]  r_sh;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_REM_W:0]   rem_sh;
    logic [DIV_REM_W:0]   rem_sub;
    logic                 q_bit;

    // remainder stays below the divisor, so one compare and subtract per bit
    always_comb begin
        rem_sh  = {r_rem, r_sh[DIV_SH_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sh  <= i_req.dividend;
            r_rem <= i_req.rem_init;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_sh  <= {r_sh[DIV_SH_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_sh;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KAMA core testbench
// Streams closing prices through the adaptive average core and compares each
// returned average and warm-up flag against a cycle-free software predictor.
// ----------------------------------------------------------------------------
// The bench drives prices at the falling edge and samples both handshakes at
// the rising edge. Every accepted price is run through the predictor at the
// edge where it is taken, and the expected average is queued; the result
// monitor pops the oldest one for every result item and compares the average
// and the warm-up flag separately. Register writes happen only with the
// result queue drained, and each write to a known register restarts the
// predictor the same way it restarts the core.
//
// Test order: reset settings, hand-picked corner cases, the longest periods,
// three randomized phases (sender mostly busy / receiver mostly stalled, the
// reverse, then no idling at all), and a long receiver hold-off that fills
// the core and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import kama_pkg::*;

    // index with no register behind it; a write there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint PRICE_MAX = (longint'(1) << PRICE_W) - 1;

    typedef struct packed {
        logic [AVG_W-1:0] average_value;
        logic             warming_up;
    } t_kama_result;

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PRICE_W-1:0]    s_axis_tdata  = '0;   // [31:0] close_price
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [AVG_W-1:0]      m_axis_tdata;         // [47:0] average_value
    logic                  m_axis_tuser;         // [0] warming_up

    kaufman_adaptive_moving_average_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_kama_result pending_averages [$];   // expected results, oldest first

    int send_idle_pct = 30;
    int recv_idle_pct = 84;
    logic recv_hold   = 1'b0;             // forces the receiver to stall

    int n_errors   = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_settled  = 0;                   // results past warm-up
    int n_settings = 0;

    // price generator state
    longint walk_price = 0;
    int     trend_dir  = 1;

    // ------------------------------------------------------------------------
    // Predictor: registers, history rings and running sums
    // ------------------------------------------------------------------------
    logic [WIN_W-1:0]    cfg_window;
    logic [PERIOD_W-1:0] cfg_fast;
    logic [PERIOD_W-1:0] cfg_slow;

    logic [PRICE_W-1:0]  hist_close [HISTORY_DEPTH];
    logic [PRICE_W-1:0]  hist_step  [HISTORY_DEPTH];
    logic [ADDR_W-1:0]   ring_wr;
    logic [PATH_W-1:0]   path_sum;
    logic [COUNT_W-1:0]  bar_count;
    logic [SEED_W-1:0]   seed_acc;
    logic [AVG_W-1:0]    kama_avg;
    logic [COEF_W-1:0]   fast_sc;
    logic [COEF_W-1:0]   slow_sc;

    function automatic logic [63:0] abs_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // EMA constant 2/(n+1) in Q1.16; a period of zero behaves as one
    function automatic logic [COEF_W-1:0] ema_coef(input logic [PERIOD_W-1:0] n);
        int unsigned d;
        d = (n == 0) ? 2 : int'(n) + 1;
        return COEF_W'((2 << FRAC_W) / d);
    endfunction

    function void kama_restart();
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_close[k] = '0;
            hist_step[k]  = '0;
        end
        ring_wr   = '0;
        path_sum  = '0;
        bar_count = '0;
        seed_acc  = '0;
        kama_avg  = '0;
        fast_sc   = ema_coef(cfg_fast);
        slow_sc   = ema_coef(cfg_slow);
        n_settings++;
    endfunction

    // Mirror a register write; unknown indexes leave everything untouched.
    function void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW: cfg_window = data[WIN_W-1:0];
            CFG_FAST:   cfg_fast   = data[PERIOD_W-1:0];
            CFG_SLOW:   cfg_slow   = data[PERIOD_W-1:0];
            default:    return;
        endcase
        kama_restart();
    endfunction

    // Advance the predictor by one close and return the result it causes.
    function t_kama_result predict_kama(input logic [PRICE_W-1:0] price);
        t_kama_result      r;
        int unsigned       w;
        int unsigned       s;
        logic [ADDR_W-1:0] old_slot;
        logic [63:0]       step;
        logic [63:0]       er;
        logic [63:0]       lin;
        logic [63:0]       sc;
        logic [63:0]       target;
        logic [63:0]       gap;
        logic [63:0]       delta;

        w = cfg_window;
        if (w > HISTORY_DEPTH - 1)
            w = HISTORY_DEPTH - 1;
        s = (cfg_slow == 0) ? 1 : cfg_slow;
        step = '0;
        er   = '0;

        if (bar_count > 0)
            step = abs_gap(price, hist_close[ring_wr - 1'b1]);

        // path length over the window; a zero window pins it at zero
        if (w == 0) begin
            path_sum = '0;
        end else begin
            path_sum = path_sum + step[PATH_W-1:0];
            if (bar_count >= w) begin
                old_slot = ring_wr - ADDR_W'(w);
                path_sum = path_sum - PATH_W'(hist_step[old_slot]);
                if (path_sum != 0) begin
                    er = (abs_gap(price, hist_close[old_slot]) << FRAC_W) / 64'(path_sum);
                    if (er > Q_ONE)
                        er = Q_ONE;
                end
            end
        end
        hist_close[ring_wr] = price;
        hist_step[ring_wr]  = step[PRICE_W-1:0];

        if (bar_count < s) begin
            // warm-up: accumulate, and seed with the mean on the last one
            seed_acc = seed_acc + SEED_W'(price);
            if (bar_count == s - 1)
                kama_avg = AVG_W'((64'(seed_acc) << FRAC_W) / s);
            r.average_value = '0;
            r.warming_up    = 1'b1;
        end else begin
            lin = (er * fast_sc + (Q_ONE - er) * slow_sc) >> FRAC_W;
            sc  = (lin * lin) >> FRAC_W;
            if (sc > Q_ONE)
                sc = Q_ONE;
            target = 64'(price) << FRAC_W;
            gap    = abs_gap(target, 64'(kama_avg));
            delta  = (sc * gap) >> FRAC_W;
            if (target >= 64'(kama_avg))
                kama_avg = kama_avg + delta[AVG_W-1:0];
            else
                kama_avg = kama_avg - delta[AVG_W-1:0];
            r.average_value = kama_avg;
            r.warming_up    = 1'b0;
        end

        ring_wr = ring_wr + 1'b1;
        if (bar_count != '1)
            bar_count = bar_count + 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Price generator: random walks, trends, flat runs with jumps, noise
    // ------------------------------------------------------------------------
    function automatic logic [PRICE_W-1:0] draw_price(input int mode);
        longint nxt;
        int     k;
        k = $urandom_range(0, 16);
        case (mode)
            0:       nxt = walk_price + longint'($urandom_range(0, 2 << k))
                           - (longint'(1) << k);
            1:       nxt = walk_price + trend_dir * longint'($urandom_range(0, 4000))
                           + longint'($urandom_range(0, 200)) - 100;
            2:       nxt = longint'($urandom());
            3:       nxt = ($urandom_range(0, 9) == 0) ? longint'($urandom()) : walk_price;
            default: nxt = walk_price + longint'($urandom_range(0, 2)) - 1;
        endcase
        if (nxt < 0)
            nxt = 0;
        if (nxt > PRICE_MAX)
            nxt = PRICE_MAX;
        walk_price = nxt;
        return nxt[PRICE_W-1:0];
    endfunction

    // Place the walk near either rail or anywhere, and pick a trend direction.
    function void start_walk();
        case ($urandom_range(0, 3))
            0:       walk_price = $urandom_range(0, 2000);
            1:       walk_price = PRICE_MAX - $urandom_range(0, 2000);
            default: walk_price = longint'($urandom());
        endcase
        trend_dir = $urandom_range(0, 1) ? 1 : -1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends right after a falling edge.
    // ------------------------------------------------------------------------

    // Offer one price; leave tvalid high on return so back-to-back items
    // flow without a bubble. Predict at the edge where the item is taken.
    task send_price(input logic [PRICE_W-1:0] price);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= price;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_averages.push_back(predict_kama(price));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Write one register once every expected result has been drained.
    task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_averages.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a forced hold-off
    always @(negedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_kama_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_averages.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got average %h warm %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_averages.pop_front();
                n_checked++;
                if (!m_axis_tuser)
                    n_settled++;
                if (m_axis_tdata !== want.average_value) begin
                    n_errors++;
                    $display("%0t: average mismatch, expected %h, got %h",
                             $time, want.average_value, m_axis_tdata);
                end
                if (m_axis_tuser !== want.warming_up) begin
                    n_errors++;
                    $display("%0t: warm-up flag mismatch, expected %b, got %b",
                             $time, want.warming_up, m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of all three registers, no writes yet.
    task test_reset_settings;
        start_walk();
        repeat (60)
            send_price(draw_price(0));
    endtask

    // Hand-picked corner cases.
    task test_corner_cases;
        // two-bar window and shortest periods; full-scale swings, flat run, clean trend
        write_register(CFG_WINDOW, 8'd2);
        write_register(CFG_FAST, 8'd1);
        write_register(CFG_SLOW, 8'd1);
        send_price(32'd0);
        send_price(32'hFFFF_FFFF);
        send_price(32'd0);
        send_price(32'hFFFF_FFFF);
        send_price(32'hFFFF_FFFF);
        // zero path length: ratio reads zero
        send_price(32'd7);
        send_price(32'd7);
        send_price(32'd7);
        // straight line: ratio saturates at one
        send_price(32'd100);
        send_price(32'd200);
        send_price(32'd300);

        // window bits above six are dropped, so this is a zero window;
        // zero periods act as one
        write_register(CFG_WINDOW, 8'hC0);
        write_register(CFG_FAST, 8'd0);
        write_register(CFG_SLOW, 8'd0);
        send_price(32'd5);
        send_price(32'd1000);
        send_price(32'd3);

        // widest window; fast period slower than the slow one
        write_register(CFG_WINDOW, 8'hFF);
        write_register(CFG_FAST, 8'd255);
        write_register(CFG_SLOW, 8'd3);
        send_price(32'd10);
        send_price(32'd20);
        send_price(32'd15);
        send_price(32'd40);
        send_price(32'd5);

        // unknown index: no restart, the average carries on
        write_register(CFG_UNUSED, 8'h55);
        send_price(32'd6);
        send_price(32'd8);
        send_price(32'hFFFF_FFFF);
    endtask

    // Longest warm-up and seed mean, widest window, fastest constant.
    task test_longest_periods;
        write_register(CFG_SLOW, 8'd255);
        write_register(CFG_WINDOW, 8'd63);
        write_register(CFG_FAST, 8'd1);
        start_walk();
        repeat (300)
            send_price(draw_price($urandom_range(0, 4)));
    endtask

    // Write a random subset of registers (at least one) with biased values.
    task pick_settings;
        logic wrote;
        wrote = 1'b0;
        while (!wrote) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_register(CFG_WINDOW, {2'($urandom()), 6'd0});
                    1:       write_register(CFG_WINDOW, {2'($urandom()), 6'd63});
                    2:       write_register(CFG_WINDOW, {2'($urandom()), 6'd1});
                    default: write_register(CFG_WINDOW,
                                            {2'($urandom()), 6'($urandom_range(2, 63))});
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_register(CFG_FAST, 8'd0);
                    1:       write_register(CFG_FAST, 8'd255);
                    2:       write_register(CFG_FAST, 8'd1);
                    3:       write_register(CFG_FAST, 8'($urandom_range(0, 255)));
                    default: write_register(CFG_FAST, 8'($urandom_range(1, 12)));
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0:       write_register(CFG_SLOW, 8'd0);
                    1:       write_register(CFG_SLOW, 8'd1);
                    2:       write_register(CFG_SLOW, 8'd255);
                    3, 4:    write_register(CFG_SLOW, 8'($urandom_range(21, 80)));
                    default: write_register(CFG_SLOW, 8'($urandom_range(2, 20)));
                endcase
                wrote = 1'b1;
            end
        end
        if ($urandom_range(0, 7) == 0)
            write_register(CFG_UNUSED, 8'($urandom()));
    endtask

    // Random settings, each followed by a burst long enough to leave warm-up.
    task test_random_settings(input int n_prices, input int send_pct, input int recv_pct);
        int sent;
        int burst;
        int mode;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_prices) begin
            pick_settings();
            burst = ((cfg_slow == 0) ? 1 : int'(cfg_slow)) + $urandom_range(8, 60);
            mode  = $urandom_range(0, 4);
            start_walk();
            repeat (burst)
                send_price(draw_price(mode));
            sent += burst;
        end
    endtask

    // Hold the receiver off for a long stretch while prices keep coming, so
    // the output register fills and the core stops taking input.
    task test_backpressure;
        write_register(CFG_WINDOW, 8'd3);
        write_register(CFG_SLOW, 8'd4);
        start_walk();
        fork
            begin
                @(posedge i_clk);
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (40)
                send_price(draw_price(0));
        join
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_window = WINDOW_RST;
        cfg_fast   = FAST_RST;
        cfg_slow   = SLOW_RST;
        kama_restart();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles 30 %, receiver 84 %
        test_reset_settings();
        test_corner_cases();
        test_longest_periods();
        test_random_settings(450, 30, 84);
        // the reverse
        test_random_settings(450, 84, 30);
        // no idling on either side
        test_random_settings(450, 0, 0);
        test_backpressure();

        // drain, then give stray results time to show up
        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Run covered %0d prices under %0d register settings, incl. zero and max",
                 n_sent, n_settings);
        $display("windows and periods; %0d results checked, %0d past warm-up",
                 n_checked, n_settled);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("%0t: timeout, %0d results still outstanding",
                 $time, pending_averages.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/kama_pkg.sv
rtl/kama_ram.sv
rtl/kama_div.sv
rtl/kaufman_adaptive_moving_average_core.sv
bench/tb.sv
